@@ src/thc_pkg.sv @@
// shared types and constants of the temperature and humidity compensation pipeline
package thc_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_T1  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T2  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T3  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H1  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H2  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H3  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H45 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H6  = 4'd7;

    localparam int     T_FINE_OFFSET = 76800;
    localparam int     HUM_MAX_Q22   = 419430400;
    localparam longint HUM_SAT_LIM   = 64'sd1099511627776;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } cal_t;

    typedef struct packed {
        logic signed [23:0] tf;
        logic signed [24:0] v;
        logic        [15:0] raw_hum;
    } temp_res_t;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic signed [23:0] fine_temp;
        logic        [16:0] hum_q10;
        logic               hum_clamped;
    } res_t;

endpackage

@@ src/thc_cfg.sv @@
// calibration register file with its write channel
module thc_cfg import thc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cal_t                  cal
);

    cal_t cal_reg;

    assign cfg_ready = 1'b1;
    assign cal       = cal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CAL_T1:  cal_reg.t1 <= cfg_data[15:0];
                REG_CAL_T2:  cal_reg.t2 <= cfg_data[15:0];
                REG_CAL_T3:  cal_reg.t3 <= cfg_data[15:0];
                REG_CAL_H1:  cal_reg.h1 <= cfg_data[7:0];
                REG_CAL_H2:  cal_reg.h2 <= cfg_data[15:0];
                REG_CAL_H3:  cal_reg.h3 <= cfg_data[7:0];
                REG_CAL_H45: begin
                    cal_reg.h4 <= cfg_data[11:0];
                    cal_reg.h5 <= cfg_data[23:12];
                end
                REG_CAL_H6:  cal_reg.h6 <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

@@ src/thc_temp.sv @@
// three-stage fine temperature pipeline
module thc_temp import thc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] raw_temp,
    input  logic [15:0] raw_hum,
    input  cal_t        cal,
    output logic        out_valid,
    input  logic        out_ready,
    output temp_res_t   out_res
);

    localparam int NS = 3;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    logic signed [17:0] tdiff;
    logic signed [33:0] tlin;
    logic signed [16:0] tdev;
    logic signed [33:0] tsq;
    logic signed [33:0] tlin_reg;
    logic        [31:0] tsq_reg;
    logic        [15:0] hum0_reg;

    logic signed [22:0] ta;
    logic signed [20:0] dsh;
    logic signed [36:0] tquad;
    logic signed [22:0] ta_reg;
    logic signed [36:0] tquad_reg;
    logic        [15:0] hum1_reg;

    logic signed [22:0] tb;
    logic signed [23:0] tf;
    logic signed [24:0] v;
    logic signed [23:0] tf_reg;
    logic signed [24:0] v_reg;
    logic        [15:0] hum2_reg;

    // ready ripples back through empty stages
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_next  = {vld_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // linear and square terms
    always_comb begin
        tdiff = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
        tlin  = tdiff * $signed(cal.t2);
        tdev  = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, cal.t1});
        tsq   = tdev * tdev;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tlin_reg <= tlin;
            tsq_reg  <= tsq[31:0];
            hum0_reg <= raw_hum;
        end
    end

    // quadratic term
    always_comb begin
        ta    = tlin_reg[33:11];
        dsh   = {1'b0, tsq_reg[31:12]};
        tquad = dsh * $signed(cal.t3);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ta_reg    <= ta;
            tquad_reg <= tquad;
            hum1_reg  <= hum0_reg;
        end
    end

    // fine temperature and its humidity offset
    always_comb begin
        tb = tquad_reg[36:14];
        tf = 24'(ta_reg) + 24'(tb);
        v  = 25'(tf) - 25'(T_FINE_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            tf_reg   <= tf;
            v_reg    <= v;
            hum2_reg <= hum1_reg;
        end
    end

    assign out_res.tf      = tf_reg;
    assign out_res.v       = v_reg;
    assign out_res.raw_hum = hum2_reg;

endmodule

@@ src/thc_hum.sv @@
// ten-stage humidity polynomial pipeline with temperature scaling and output register
module thc_hum import thc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  temp_res_t in_res,
    input  cal_t      cal,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      out_res
);

    localparam int NS = 10;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    logic signed [15:0] tc_reg [NS];
    logic signed [23:0] tf_reg [NS];

    // stage 0
    logic signed [25:0] tf4;
    logic signed [26:0] tf5;
    logic signed [18:0] tcw;
    logic signed [15:0] tcs;
    logic signed [36:0] hv5;
    logic signed [32:0] p6;
    logic signed [33:0] p3;
    logic signed [36:0] hv5_reg;
    logic signed [32:0] p6_reg;
    logic signed [33:0] p3_reg;
    logic        [15:0] hum_reg;

    // stage 1
    logic signed [37:0] hsum;
    logic signed [22:0] p3s;
    logic signed [22:0] b1_reg;
    logic signed [23:0] c_reg;
    logic signed [22:0] ha_reg [1:4];

    // stages 2 to 5
    logic signed [46:0] bb;
    logic signed [46:0] bb_reg;
    logic signed [36:0] bb_sh;
    logic signed [37:0] e;
    logic signed [53:0] pe;
    logic signed [53:0] pe_reg;
    logic signed [53:0] pr;
    logic signed [39:0] bq_reg;
    logic signed [62:0] xw;
    logic signed [62:0] x_reg;

    // stages 6 to 9
    logic signed [41:0] xsat;
    logic signed [41:0] xsat_reg [6:8];
    logic signed [26:0] xs_reg;
    logic signed [53:0] sqw;
    logic        [52:0] sq_reg;
    logic        [45:0] sqsh;
    logic        [53:0] tq;
    logic        [53:0] tq_reg;
    logic signed [50:0] tsh;
    logic signed [51:0] hy;
    logic        [16:0] hq;
    logic               hcl;
    logic        [16:0] hq_reg;
    logic               hcl_reg;

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_next  = {vld_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // temperature in hundredths, saturated, and the products of v with h5, h6 and h3
    always_comb begin
        tf4 = {in_res.tf, 2'b00};
        tf5 = 27'(in_res.tf) + 27'(tf4) + 27'sd128;
        tcw = tf5[26:8];
        if (tcw > 19'sd32767) begin
            tcs = 16'sh7FFF;
        end else if (tcw < -19'sd32768) begin
            tcs = 16'sh8000;
        end else begin
            tcs = tcw[15:0];
        end
        hv5 = $signed(cal.h5) * in_res.v;
        p6  = in_res.v * $signed(cal.h6);
        p3  = in_res.v * $signed({1'b0, cal.h3});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tc_reg[0] <= tcs;
            tf_reg[0] <= in_res.tf;
            hv5_reg   <= hv5;
            p6_reg    <= p6;
            p3_reg    <= p3;
            hum_reg   <= in_res.raw_hum;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                tc_reg[k] <= tc_reg[k-1];
                tf_reg[k] <= tf_reg[k-1];
            end
        end
    end

    // humidity offset and slope, temperature factor operands
    always_comb begin
        hsum = $signed({8'b0, hum_reg, 14'b0})
             - $signed({{6{cal.h4[11]}}, cal.h4, 20'b0})
             - 38'(hv5_reg) + 38'sd16384;
        p3s  = p3_reg[33:11];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ha_reg[1] <= hsum[37:15];
            b1_reg    <= p6_reg[32:10];
            c_reg     <= 24'(p3s) + 24'sd32768;
        end
        for (int k = 2; k <= 4; k++) begin
            if (en[k]) begin
                ha_reg[k] <= ha_reg[k-1];
            end
        end
    end

    // temperature factor product
    assign bb = b1_reg * c_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            bb_reg <= bb;
        end
    end

    // gain product
    always_comb begin
        bb_sh = bb_reg[46:10];
        e     = 38'(bb_sh) + 38'sd2097152;
        pe    = e * $signed(cal.h2);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            pe_reg <= pe;
        end
    end

    // rounding of the gain product
    assign pr = pe_reg + 54'sd8192;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            bq_reg <= pr[53:14];
        end
    end

    assign xw = ha_reg[4] * bq_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            x_reg <= xw;
        end
    end

    // runaway limit before the saturation term
    always_comb begin
        if (x_reg > 63'(HUM_SAT_LIM)) begin
            xsat = 42'(HUM_SAT_LIM);
        end else if (x_reg < -63'(HUM_SAT_LIM)) begin
            xsat = -42'(HUM_SAT_LIM);
        end else begin
            xsat = x_reg[41:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            xsat_reg[6] <= xsat;
            xs_reg      <= xsat[41:15];
        end
        for (int k = 7; k <= 8; k++) begin
            if (en[k]) begin
                xsat_reg[k] <= xsat_reg[k-1];
            end
        end
    end

    assign sqw = xs_reg * xs_reg;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            sq_reg <= sqw[52:0];
        end
    end

    always_comb begin
        sqsh = sq_reg[52:7];
        tq   = sqsh * cal.h1;
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            tq_reg <= tq;
        end
    end

    // saturation term and clamp to 0..100 %RH
    always_comb begin
        tsh = {1'b0, tq_reg[53:4]};
        hy  = 52'(xsat_reg[8]) - 52'(tsh);
        if (hy < 52'sd0) begin
            hq  = '0;
            hcl = 1'b1;
        end else if (hy > 52'(HUM_MAX_Q22)) begin
            hq  = 17'(HUM_MAX_Q22 >> 12);
            hcl = 1'b1;
        end else begin
            hq  = hy[28:12];
            hcl = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            hq_reg  <= hq;
            hcl_reg <= hcl;
        end
    end

    assign out_res.temp_centi  = tc_reg[NS-1];
    assign out_res.fine_temp   = tf_reg[NS-1];
    assign out_res.hum_q10     = hq_reg;
    assign out_res.hum_clamped = hcl_reg;

endmodule

@@ src/temp_humidity_compensation.sv @@
// top level of the temperature and humidity compensation block
// Takes one raw temperature/humidity pair per cycle, unless held by back-pressure, and returns
// fine temperature, temperature in 0.01 degC (saturated to 16 bits), and humidity in 1/1024
// %RH clamped to 0..100 with a clamp flag. The datapath is a 13-stage pipeline: three stages
// for the temperature terms and ten for the humidity polynomial, with no stage chaining one
// multiplier into another. Each stage holds its item under back-pressure and the input side
// keeps accepting while empty stages remain. Calibration registers are written over the cfg
// channel (always ready); the user must write them only while no transfer is in flight, which
// the block itself does not enforce. Indexes above 7 are ignored.
module temp_humidity_compensation import thc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // raw_temp[19:0], raw_hum[35:20], rest unused
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,   // temp_centi[15:0], fine_temp[47:16], hum_q10[64:48]
    output logic [0:0]            m_tuser,   // hum_clamped
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cal_t      cal;
    temp_res_t t_res;
    logic      t_valid;
    logic      t_ready;
    res_t      h_res;

    thc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    thc_temp u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_temp  (s_tdata[19:0]),
        .raw_hum   (s_tdata[35:20]),
        .cal       (cal),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_res   (t_res)
    );

    thc_hum u_hum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_res    (t_res),
        .cal       (cal),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (h_res)
    );

    assign m_tdata = {7'b0, h_res.hum_q10, 32'(h_res.fine_temp), h_res.temp_centi};
    assign m_tuser = h_res.hum_clamped;

endmodule
